### sv/tsr_pkg.sv
// shared constants, codes and types for the timestamp rescaler
package tsr_pkg;

  localparam int DEF_TB_BITS = 32;
  localparam int US_PER_SEC  = 1000000;
  localparam int US_BITS     = 20;
  // quotient bits resolved by the divider chain, one per cell
  localparam int Q_BITS      = 66;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NEG    = 3'd1,
    ST_BAD    = 3'd2,
    ST_OVF    = 3'd3,
    ST_BEFORE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_DIV    = 3'd0,
    OP_STAMP  = 3'd1,
    OP_NORM   = 3'd2,
    OP_SIGNED = 3'd3,
    OP_FRAME  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_SRC_NUM = 3'd0,
    REG_SRC_DEN = 3'd1,
    REG_ORG_NUM = 3'd2,
    REG_ORG_DEN = 3'd3,
    REG_ORG_STAMP = 3'd4,
    REG_RATE_NUM = 3'd5,
    REG_RATE_DEN = 3'd6
  } reg_idx_t;

  // control that rides along with each item through the pipeline
  typedef struct packed {
    logic       vld;
    logic [2:0] op;
    status_t    st;
    logic       neg;
  } side_t;

endpackage

### sv/tsr_in_if.sv
// input item channel of the timestamp rescaler
interface tsr_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [63:0] value;
  logic signed [63:0] divisor;

  modport source(output valid, output operation, output value, output divisor,
                 input ready);
  modport sink(input valid, input operation, input value, input divisor,
               output ready);
endinterface

### sv/tsr_out_if.sv
// result item channel of the timestamp rescaler
interface tsr_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result;
  logic [2:0]         status;

  modport source(output valid, output result, output status, input ready);
  modport sink(input valid, input result, input status, output ready);
endinterface

### sv/timestamp_rescale_to_microseconds_top.sv
// top level of the timestamp rescaler: config registers, divider chain, rounding
//
//   channel  dir  handshake        payload
//   din      in   valid / ready    operation[2:0], value[63:0], divisor[63:0]
//   dout     out  valid / ready    result[63:0], status[2:0]
//   cfg      in   cfg_we           cfg_index[2:0], cfg_data[63:0]
//
// one item per cycle unless dout is blocked; eight front stages (operand register, three
// multiplier levels with registered partial products and sums, offset combine), one range
// check, 66 division cells (one quotient bit each) and the rounding/output register
// synchronous reset clears all valid flags and loads the register defaults
// the whole pipeline advances together; it holds only while dout has an
// item that the sink does not take
module timestamp_rescale_to_microseconds_top #(
  parameter int TIMEBASE_BITS = tsr_pkg::DEF_TB_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data,
  tsr_in_if.sink                   din,
  tsr_out_if.source                dout
);

  localparam int TB = TIMEBASE_BITS;
  localparam int YW = (TB > tsr_pkg::US_BITS) ? TB : tsr_pkg::US_BITS;
  localparam int MW = 64 + TB + YW;
  localparam int NW = MW + 1 + tsr_pkg::US_BITS;
  localparam int DW = (2 * TB > 64) ? 2 * TB : 64;
  localparam int QB = tsr_pkg::Q_BITS;

  // global advance: output slot free or being emptied
  logic en;
  assign en        = !dout.valid || dout.ready;
  assign din.ready = en;

  // configuration registers
  logic [TB-1:0] src_num, src_den, org_num, org_den, rate_num, rate_den;
  logic [63:0]   org_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_num   <= TB'(64'd1);
      src_den   <= TB'(64'd1000000);
      org_num   <= TB'(64'd1);
      org_den   <= TB'(64'd1000000);
      org_stamp <= 64'd0;
      rate_num  <= TB'(64'd30);
      rate_den  <= TB'(64'd1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsr_pkg::REG_SRC_NUM:   src_num   <= cfg_data[TB-1:0];
        tsr_pkg::REG_SRC_DEN:   src_den   <= cfg_data[TB-1:0];
        tsr_pkg::REG_ORG_NUM:   org_num   <= cfg_data[TB-1:0];
        tsr_pkg::REG_ORG_DEN:   org_den   <= cfg_data[TB-1:0];
        tsr_pkg::REG_ORG_STAMP: org_stamp <= cfg_data;
        tsr_pkg::REG_RATE_NUM:  rate_num  <= cfg_data[TB-1:0];
        tsr_pkg::REG_RATE_DEN:  rate_den  <= cfg_data[TB-1:0];
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // front end: exact magnitude numerator and denominator
  tsr_pkg::side_t f_side;
  logic [NW-1:0]  f_num;
  logic [DW-1:0]  f_den;

  tsr_front #(.TB(TB)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (din.valid),
    .operation (din.operation),
    .value     (din.value),
    .divisor   (din.divisor),
    .src_num   (src_num),
    .src_den   (src_den),
    .org_num   (org_num),
    .org_den   (org_den),
    .org_stamp (org_stamp),
    .rate_num  (rate_num),
    .rate_den  (rate_den),
    .side_o    (f_side),
    .num_o     (f_num),
    .den_o     (f_den)
  );

  // range check: a truncated quotient of 2^66 or more is an overflow for sure,
  // otherwise the top bits of the numerator seed the remainder below d
  logic [NW-1:0]  num_hi;
  logic           too_big;
  assign num_hi  = f_num >> QB;
  assign too_big = num_hi >= NW'(f_den);

  tsr_pkg::side_t c_side [QB+1];
  logic [DW-1:0]  c_rem  [QB+1];
  logic [QB-1:0]  c_low  [QB+1];
  logic [QB-1:0]  c_q    [QB+1];
  logic [DW-1:0]  c_d    [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_side[0] <= '0;
    end else if (en) begin
      c_side[0] <= '{vld: f_side.vld, op: f_side.op,
                     st: (f_side.st == tsr_pkg::ST_OK && too_big) ? tsr_pkg::ST_OVF : f_side.st,
                     neg: f_side.neg};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_rem[0] <= num_hi[DW-1:0];
      c_low[0] <= f_num[QB-1:0];
      c_q[0]   <= '0;
      c_d[0]   <= f_den;
    end
  end

  // division chain, msb quotient bit first
  for (genvar i = 0; i < QB; i++) begin : g_cell
    tsr_cell #(.DW(DW), .QB(QB)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .side_i (c_side[i]),
      .rem_i  (c_rem[i]),
      .low_i  (c_low[i]),
      .q_i    (c_q[i]),
      .d_i    (c_d[i]),
      .side_o (c_side[i+1]),
      .rem_o  (c_rem[i+1]),
      .low_o  (c_low[i+1]),
      .q_o    (c_q[i+1]),
      .d_o    (c_d[i+1])
    );
  end

  // round half to even, limit check, sign and final status
  tsr_pkg::side_t   l_side;
  logic [DW:0]      r2, dx;
  logic             up, over;
  logic [QB:0]      qr;
  tsr_pkg::status_t st_fin;
  logic [63:0]      res_fin;
  logic [2:0]       out_op;

  assign l_side = c_side[QB];
  assign r2     = {c_rem[QB], 1'b0};
  assign dx     = {1'b0, c_d[QB]};
  assign up     = (r2 > dx) || (r2 == dx && c_q[QB][0]);
  assign qr     = {1'b0, c_q[QB]} + (QB+1)'(up);
  // a negative offset may reach 2^63, anything else stops at 2^63 - 1
  assign over   = l_side.neg ? (qr > (QB+1)'(64'h8000_0000_0000_0000))
                             : (qr > (QB+1)'(64'h7FFF_FFFF_FFFF_FFFF));

  always_comb begin
    st_fin  = l_side.st;
    res_fin = 64'd0;
    if (st_fin == tsr_pkg::ST_OK) begin
      if (over) begin
        st_fin = tsr_pkg::ST_OVF;
      end else if (l_side.neg && qr != '0) begin
        if (l_side.op == tsr_pkg::OP_NORM) st_fin = tsr_pkg::ST_BEFORE;
        else res_fin = ~qr[63:0] + 64'd1;
      end else begin
        res_fin = qr[63:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= l_side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.result <= res_fin;
      dout.status <= st_fin;
      out_op      <= l_side.op;
    end
  end

  // failed items always carry a zero result
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.status != tsr_pkg::ST_OK |-> dout.result == 64'd0)
    else $error("nonzero result with failing status");

  // only the signed offset can give a negative microsecond value
  a_neg_only_signed: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.status == tsr_pkg::ST_OK && dout.result[63]
      |-> out_op == tsr_pkg::OP_SIGNED)
    else $error("negative result from an unsigned operation");

  // the pipeline only holds behind a waiting output item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> dout.valid && !dout.ready)
    else $error("input stalled without a blocked output");

endmodule

### sv/tsr_front.sv
// front end: pipelined limb multiplier, checks, magnitudes and the exact numerator and denominator
module tsr_mul #(
  parameter int AW = 64,
  parameter int BW = 32,
  localparam int NA = (AW + 31) / 32,
  localparam int NB = (BW + 31) / 32,
  localparam int SW = (NA + NB) * 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  // 32x32 partial products registered, then summed into the registered product
  logic [NA*32-1:0] ax;
  logic [NB*32-1:0] bx;
  logic [63:0]      pp [NA][NB];
  logic [SW-1:0]    sum;

  assign ax = (NA*32)'(a);
  assign bx = (NB*32)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ax[i*32 +: 32] * bx[j*32 +: 32];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[AW+BW-1:0];
    end
  end

endmodule

module tsr_front #(
  parameter int TB = tsr_pkg::DEF_TB_BITS,
  localparam int YW = (TB > tsr_pkg::US_BITS) ? TB : tsr_pkg::US_BITS,
  localparam int MW = 64 + TB + YW,
  localparam int NW = MW + 1 + tsr_pkg::US_BITS,
  localparam int DW = (2 * TB > 64) ? 2 * TB : 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [2:0]          operation,
  input  logic [63:0]         value,
  input  logic [63:0]         divisor,
  input  logic [TB-1:0]       src_num,
  input  logic [TB-1:0]       src_den,
  input  logic [TB-1:0]       org_num,
  input  logic [TB-1:0]       org_den,
  input  logic [63:0]         org_stamp,
  input  logic [TB-1:0]       rate_num,
  input  logic [TB-1:0]       rate_den,
  output tsr_pkg::side_t      side_o,
  output logic [NW-1:0]       num_o,
  output logic [DW-1:0]       den_o
);

  localparam int UB = tsr_pkg::US_BITS;
  localparam logic [UB-1:0] US_K = UB'(tsr_pkg::US_PER_SEC);

  // magnitudes and signs
  logic          vn, dn, sn_n, sd_n, on_n, od_n, o_n, rn_n, rd_n;
  logic [63:0]   vm, dm, om;
  logic [TB-1:0] sn, sd, onm, odm, rn, rd;
  tsr_pkg::status_t st;
  logic          off;
  logic [TB-1:0] x;
  logic [YW-1:0] y;
  logic [63:0]   dbase;

  assign vn   = value[63];
  assign dn   = divisor[63];
  assign o_n  = org_stamp[63];
  assign sn_n = src_num[TB-1];
  assign sd_n = src_den[TB-1];
  assign on_n = org_num[TB-1];
  assign od_n = org_den[TB-1];
  assign rn_n = rate_num[TB-1];
  assign rd_n = rate_den[TB-1];
  assign vm   = vn ? (~value + 64'd1) : value;
  assign dm   = dn ? (~divisor + 64'd1) : divisor;
  assign om   = o_n ? (~org_stamp + 64'd1) : org_stamp;
  assign sn   = sn_n ? (~src_num + TB'(1)) : src_num;
  assign sd   = sd_n ? (~src_den + TB'(1)) : src_den;
  assign onm  = on_n ? (~org_num + TB'(1)) : org_num;
  assign odm  = od_n ? (~org_den + TB'(1)) : org_den;
  assign rn   = rn_n ? (~rate_num + TB'(1)) : rate_num;
  assign rd   = rd_n ? (~rate_den + TB'(1)) : rate_den;
  assign off  = (operation == tsr_pkg::OP_NORM) || (operation == tsr_pkg::OP_SIGNED);

  always_comb begin
    st    = tsr_pkg::ST_OK;
    x     = TB'(1);
    y     = YW'(1);
    dbase = dm;
    case (operation)
      tsr_pkg::OP_DIV: begin
        if (dn || dm == 64'd0) st = tsr_pkg::ST_BAD;
        else if (vn) st = tsr_pkg::ST_NEG;
      end
      tsr_pkg::OP_STAMP: begin
        x     = sn;
        y     = YW'(tsr_pkg::US_PER_SEC);
        dbase = 64'(sd);
        if (sd == '0) st = tsr_pkg::ST_BAD;
        else if (vn) st = tsr_pkg::ST_NEG;
        else if ((sn_n != sd_n) && vm != 64'd0 && sn != '0) st = tsr_pkg::ST_NEG;
      end
      tsr_pkg::OP_NORM, tsr_pkg::OP_SIGNED: begin
        x = sn;
        y = YW'(odm);
        if (sd == '0 || odm == '0) st = tsr_pkg::ST_BAD;
      end
      tsr_pkg::OP_FRAME: begin
        x     = rd;
        y     = YW'(tsr_pkg::US_PER_SEC);
        dbase = 64'(rn);
        if (rd == '0) st = tsr_pkg::ST_BAD;
        else if (vn) st = tsr_pkg::ST_NEG;
        else if (rn == '0 || rn_n != rd_n) st = tsr_pkg::ST_BAD;
      end
      default: st = tsr_pkg::ST_BAD;
    endcase
  end

  // stage 0: operand registers
  tsr_pkg::side_t s0_side;
  logic [63:0]    s0_vm, s0_om, s0_dbase;
  logic [TB-1:0]  s0_x, s0_onm, s0_sd, s0_odm;
  logic [YW-1:0]  s0_y;
  logic           s0_off, s0_s1, s0_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_side <= '0;
    end else if (en) begin
      s0_side <= '{vld: in_vld, op: operation, st: st, neg: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_vm    <= vm;
      s0_om    <= om;
      s0_dbase <= dbase;
      s0_x     <= x;
      s0_y     <= y;
      s0_onm   <= onm;
      s0_sd    <= sd;
      s0_odm   <= odm;
      s0_off   <= off;
      s0_s1    <= vn ^ sn_n ^ sd_n;
      s0_s2    <= o_n ^ on_n ^ od_n;
    end
  end

  // stages 1 and 2: first products
  logic [63+TB:0]   p1_w, p2_w;
  logic [2*TB-1:0]  dd_w;
  tsr_pkg::side_t   m1_side  [2];
  logic [63:0]      m1_dbase [2];
  logic [YW-1:0]    m1_y     [2];
  logic [TB-1:0]    m1_sd    [2];
  logic             m1_off [2], m1_s1 [2], m1_s2 [2];

  tsr_mul #(.AW(64), .BW(TB)) u_p1 (.clk(clk), .en(en), .a(s0_vm), .b(s0_x), .p(p1_w));
  tsr_mul #(.AW(64), .BW(TB)) u_p2 (.clk(clk), .en(en), .a(s0_om), .b(s0_onm), .p(p2_w));
  tsr_mul #(.AW(TB), .BW(TB)) u_dd (.clk(clk), .en(en), .a(s0_sd), .b(s0_odm), .p(dd_w));

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_side[0] <= '0;
      m1_side[1] <= '0;
    end else if (en) begin
      m1_side[0] <= s0_side;
      m1_side[1] <= m1_side[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_dbase[0] <= s0_dbase;
      m1_dbase[1] <= m1_dbase[0];
      m1_y[0]     <= s0_y;
      m1_y[1]     <= m1_y[0];
      m1_sd[0]    <= s0_sd;
      m1_sd[1]    <= m1_sd[0];
      m1_off[0]   <= s0_off;
      m1_off[1]   <= m1_off[0];
      m1_s1[0]    <= s0_s1;
      m1_s1[1]    <= m1_s1[0];
      m1_s2[0]    <= s0_s2;
      m1_s2[1]    <= m1_s2[0];
    end
  end

  // stages 3 and 4: second products
  logic [DW-1:0]    d_w;
  logic [MW-1:0]    t1_w, t2_w;
  logic [63+2*TB:0] t2_p;
  tsr_pkg::side_t   m2_side [2];
  logic [DW-1:0]    m2_d    [2];
  logic             m2_off [2], m2_s1 [2], m2_s2 [2];

  assign d_w = m1_off[1] ? DW'(dd_w) : DW'(m1_dbase[1]);

  tsr_mul #(.AW(64 + TB), .BW(YW)) u_t1 (
    .clk(clk), .en(en), .a(p1_w), .b(m1_y[1]), .p(t1_w)
  );
  tsr_mul #(.AW(64 + TB), .BW(TB)) u_t2 (
    .clk(clk), .en(en), .a(p2_w), .b(m1_sd[1]), .p(t2_p)
  );
  assign t2_w = MW'(t2_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_side[0] <= '0;
      m2_side[1] <= '0;
    end else if (en) begin
      m2_side[0] <= m1_side[1];
      m2_side[1] <= m2_side[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_d[0]   <= d_w;
      m2_d[1]   <= m2_d[0];
      m2_off[0] <= m1_off[1];
      m2_off[1] <= m2_off[0];
      m2_s1[0]  <= m1_s1[1];
      m2_s1[1]  <= m2_s1[0];
      m2_s2[0]  <= m1_s2[1];
      m2_s2[1]  <= m2_s2[0];
    end
  end

  // stage 5: signed combine of the two offset terms
  logic [MW:0]    n_w;
  logic           neg_w;
  tsr_pkg::side_t s3_side;
  logic [MW:0]    s3_n;
  logic [DW-1:0]  s3_d;
  logic           s3_off;

  always_comb begin
    n_w   = {1'b0, t1_w};
    neg_w = 1'b0;
    if (m2_off[1]) begin
      if (m2_s1[1] != m2_s2[1]) begin
        n_w   = {1'b0, t1_w} + {1'b0, t2_w};
        neg_w = m2_s1[1];
      end else if (t1_w >= t2_w) begin
        n_w   = {1'b0, t1_w} - {1'b0, t2_w};
        neg_w = m2_s1[1];
      end else begin
        n_w   = {1'b0, t2_w} - {1'b0, t1_w};
        neg_w = !m2_s1[1];
      end
      if (n_w == '0) neg_w = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side <= '0;
    end else if (en) begin
      s3_side <= '{vld: m2_side[1].vld, op: m2_side[1].op, st: m2_side[1].st, neg: neg_w};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_n   <= n_w;
      s3_d   <= m2_d[1];
      s3_off <= m2_off[1];
    end
  end

  // stages 6 and 7: offsets scaled to microseconds
  logic [NW-1:0]  nus_w;
  tsr_pkg::side_t m3_side [2];
  logic [MW:0]    m3_n    [2];
  logic [DW-1:0]  m3_d    [2];
  logic           m3_off  [2];

  tsr_mul #(.AW(MW + 1), .BW(UB)) u_us (
    .clk(clk), .en(en), .a(s3_n), .b(US_K), .p(nus_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_side[0] <= '0;
      m3_side[1] <= '0;
    end else if (en) begin
      m3_side[0] <= s3_side;
      m3_side[1] <= m3_side[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_n[0]   <= s3_n;
      m3_n[1]   <= m3_n[0];
      m3_d[0]   <= s3_d;
      m3_d[1]   <= m3_d[0];
      m3_off[0] <= s3_off;
      m3_off[1] <= m3_off[0];
    end
  end

  assign side_o = m3_side[1];
  assign num_o  = m3_off[1] ? nus_w : NW'(m3_n[1]);
  assign den_o  = m3_d[1];

endmodule

### sv/tsr_cell.sv
// one restoring division cell: resolves one quotient bit
module tsr_cell #(
  parameter int DW = 64,
  parameter int QB = tsr_pkg::Q_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  tsr_pkg::side_t side_i,
  input  logic [DW-1:0]  rem_i,
  input  logic [QB-1:0]  low_i,
  input  logic [QB-1:0]  q_i,
  input  logic [DW-1:0]  d_i,
  output tsr_pkg::side_t side_o,
  output logic [DW-1:0]  rem_o,
  output logic [QB-1:0]  low_o,
  output logic [QB-1:0]  q_o,
  output logic [DW-1:0]  d_o
);

  logic [DW:0] trial, diff;
  logic        ge;

  assign trial = {rem_i, low_i[QB-1]};
  assign ge    = trial >= {1'b0, d_i};
  assign diff  = trial - {1'b0, d_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o <= '0;
    end else if (en) begin
      side_o <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low_o <= {low_i[QB-2:0], 1'b0};
      q_o   <= {q_i[QB-2:0], ge};
      d_o   <= d_i;
    end
  end

endmodule

### tb/timestamp_rescale_to_microseconds_top_test.sv
// self-checking testbench for the timestamp rescaler: random and directed items with scoreboard
module timestamp_rescale_to_microseconds_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_BITS = tsr_pkg::DEF_TB_BITS;
  // index past the register file, writes to it are dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 90;

  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic [63:0]      result;
    tsr_pkg::status_t status;
  } rescaled_t;

  // scoreboard: register shadow, microsecond predictor and expected-result queue
  class rescale_scoreboard;
    logic [63:0] regs [7];
    rescaled_t   pending_q [$];
    int          errors;
    int          items_in;
    int          results_out;

    function void reset_regs();
      regs[tsr_pkg::REG_SRC_NUM] = 64'd1;
      regs[tsr_pkg::REG_SRC_DEN] = 64'd1000000;
      regs[tsr_pkg::REG_ORG_NUM] = 64'd1;
      regs[tsr_pkg::REG_ORG_DEN] = 64'd1000000;
      regs[tsr_pkg::REG_ORG_STAMP] = 64'd0;
      regs[tsr_pkg::REG_RATE_NUM] = 64'd30;
      regs[tsr_pkg::REG_RATE_DEN] = 64'd1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      logic [63:0] msk;
      msk = (idx == tsr_pkg::REG_ORG_STAMP) ? '1 : ((64'd1 << TB_BITS) - 64'd1);
      if (idx <= tsr_pkg::REG_RATE_DEN) regs[idx] = data & msk;
    endfunction

    // sign and magnitude of a w-bit two's complement word
    function logic [64:0] sign_mag(logic [63:0] raw, int w);
      logic [63:0] msk;
      logic        sgn;
      msk = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      raw = raw & msk;
      sgn = raw[w-1];
      return {sgn, sgn ? ((-raw) & msk) : raw};
    endfunction

    // n / d rounded half to even; 0 when the magnitude passes the limit
    function bit round_even(wide_t n, wide_t d, logic [63:0] limit, output logic [63:0] mag);
      wide_t q;
      wide_t r;
      q = n / d;
      r = n % d;
      if ((r << 1) > d || ((r << 1) == d && q[0])) q = q + 1;
      mag = q[63:0];
      return q <= {192'd0, limit};
    endfunction

    function rescaled_t rescale(logic [2:0] op, logic [63:0] val, logic [63:0] dvs);
      logic [64:0]      v, dv, sn, sd, on, od, om, rn, rd;
      wide_t            t1, t2, n;
      logic             s1, s2, neg;
      logic [63:0]      mag;
      tsr_pkg::status_t st;
      logic [63:0]      res;
      v = sign_mag(val, 64);
      dv = sign_mag(dvs, 64);
      sn = sign_mag(regs[tsr_pkg::REG_SRC_NUM], TB_BITS);
      sd = sign_mag(regs[tsr_pkg::REG_SRC_DEN], TB_BITS);
      on = sign_mag(regs[tsr_pkg::REG_ORG_NUM], TB_BITS);
      od = sign_mag(regs[tsr_pkg::REG_ORG_DEN], TB_BITS);
      om = sign_mag(regs[tsr_pkg::REG_ORG_STAMP], 64);
      rn = sign_mag(regs[tsr_pkg::REG_RATE_NUM], TB_BITS);
      rd = sign_mag(regs[tsr_pkg::REG_RATE_DEN], TB_BITS);
      st = tsr_pkg::ST_OK;
      res = '0;
      mag = '0;
      case (op)
        tsr_pkg::OP_DIV: begin
          if (dv[64] || dv[63:0] == 0) st = tsr_pkg::ST_BAD;
          else if (v[64]) st = tsr_pkg::ST_NEG;
          else if (!round_even(wide_t'(v[63:0]), wide_t'(dv[63:0]),
                               64'h7FFF_FFFF_FFFF_FFFF, mag))
            st = tsr_pkg::ST_OVF;
          else res = mag;
        end
        tsr_pkg::OP_STAMP: begin
          n = wide_t'(v[63:0]) * wide_t'(sn[63:0]) * wide_t'(tsr_pkg::US_PER_SEC);
          if (sd[63:0] == 0) st = tsr_pkg::ST_BAD;
          else if (v[64]) st = tsr_pkg::ST_NEG;
          else if (sn[64] != sd[64] && n != 0) st = tsr_pkg::ST_NEG;
          else if (!round_even(n, wide_t'(sd[63:0]), 64'h7FFF_FFFF_FFFF_FFFF, mag))
            st = tsr_pkg::ST_OVF;
          else res = mag;
        end
        tsr_pkg::OP_NORM, tsr_pkg::OP_SIGNED: begin
          if (sd[63:0] == 0 || od[63:0] == 0) begin
            st = tsr_pkg::ST_BAD;
          end else begin
            // both sides over the common denominator src_den * org_den
            s1 = v[64] ^ sn[64] ^ sd[64];
            s2 = om[64] ^ on[64] ^ od[64];
            t1 = wide_t'(v[63:0]) * wide_t'(sn[63:0]) * wide_t'(od[63:0]);
            t2 = wide_t'(om[63:0]) * wide_t'(on[63:0]) * wide_t'(sd[63:0]);
            if (s1 != s2) begin
              n = t1 + t2;
              neg = s1;
            end else if (t1 >= t2) begin
              n = t1 - t2;
              neg = s1;
            end else begin
              n = t2 - t1;
              neg = !s1;
            end
            if (n == 0) neg = 1'b0;
            n = n * wide_t'(tsr_pkg::US_PER_SEC);
            if (!round_even(n, wide_t'(sd[63:0]) * wide_t'(od[63:0]),
                            neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF, mag))
              st = tsr_pkg::ST_OVF;
            else if (neg && mag != 0) begin
              if (op == tsr_pkg::OP_NORM) st = tsr_pkg::ST_BEFORE;
              else res = -mag;
            end else res = mag;
          end
        end
        tsr_pkg::OP_FRAME: begin
          if (rd[63:0] == 0) st = tsr_pkg::ST_BAD;
          else if (v[64]) st = tsr_pkg::ST_NEG;
          else if (rn[63:0] == 0 || rn[64] != rd[64]) st = tsr_pkg::ST_BAD;
          else if (!round_even(wide_t'(v[63:0]) * wide_t'(rd[63:0]) *
                               wide_t'(tsr_pkg::US_PER_SEC),
                               wide_t'(rn[63:0]), 64'h7FFF_FFFF_FFFF_FFFF, mag))
            st = tsr_pkg::ST_OVF;
          else res = mag;
        end
        default: st = tsr_pkg::ST_BAD;
      endcase
      if (st != tsr_pkg::ST_OK) res = '0;
      return '{result: res, status: st};
    endfunction

    function void note_input(logic [2:0] op, logic [63:0] val, logic [63:0] dvs);
      pending_q.push_back(rescale(op, val, dvs));
      items_in++;
    endfunction

    function void check_result(logic [63:0] res, logic [2:0] st);
      rescaled_t want;
      results_out++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: actual result %0d status %0d", $time,
                 $signed(res), st);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (res !== want.result) begin
        $display("%0t: result mismatch: expected %0d actual %0d", $time,
                 $signed(want.result), $signed(res));
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  tsr_in_if  din();
  tsr_out_if dout();

  timestamp_rescale_to_microseconds_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .din      (din.sink),
    .dout     (dout.source)
  );

  rescale_scoreboard sb;
  // set by the stimulus to ask the receiver for a long hold-off
  bit hold_req;
  int settings_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: checks results, drives ready on a changing pattern, watches for stalls
  initial begin : receiver
    int hold_left;
    int mode;
    int phase_left;
    int idle_cycles;
    bit moved;
    hold_left = 0;
    mode = 0;
    phase_left = 0;
    idle_cycles = 0;
    dout.ready = 1'b0;
    forever begin
      @(posedge clk);
      moved = 1'b0;
      if (!rst) begin
        if (dout.valid && dout.ready) begin
          sb.check_result(dout.result, dout.status);
          moved = 1'b1;
        end
        if (din.valid && din.ready) moved = 1'b1;
        // watchdog: only cycles with nothing accepted on either side count
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
      if (phase_left == 0) begin
        // new stall style: always ready, random, or a square wave
        mode = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        dout.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        dout.ready <= 1'b0;
      end else begin
        case (mode)
          0: dout.ready <= 1'b1;
          1: dout.ready <= ($urandom_range(0, 99) < 65);
          default: dout.ready <= phase_left[2];
        endcase
      end
    end
  end

  // one item on din; returns once it has been taken
  task automatic send_item(logic [2:0] op, logic [63:0] val, logic [63:0] dvs);
    din.valid <= 1'b1;
    din.operation <= op;
    din.value <= val;
    din.divisor <= dvs;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    sb.note_input(op, val, dvs);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_setting(logic [63:0] s_num, logic [63:0] s_den, logic [63:0] o_num,
                              logic [63:0] o_den, logic [63:0] stamp, logic [63:0] r_num,
                              logic [63:0] r_den);
    write_reg(tsr_pkg::REG_SRC_NUM, s_num);
    write_reg(tsr_pkg::REG_SRC_DEN, s_den);
    write_reg(tsr_pkg::REG_ORG_NUM, o_num);
    write_reg(tsr_pkg::REG_ORG_DEN, o_den);
    write_reg(tsr_pkg::REG_ORG_STAMP, stamp);
    write_reg(tsr_pkg::REG_RATE_NUM, r_num);
    write_reg(tsr_pkg::REG_RATE_DEN, r_den);
    settings_run++;
  endtask

  // stop offering items and wait for every outstanding result
  task automatic drain();
    din.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($urandom_range(0, 2000000));
      4:          return -64'($urandom_range(1, 100000));
      5, 6:       return rand_word();
      7: begin
        case ($urandom_range(0, 3))
          0: return 64'h7FFF_FFFF_FFFF_FFFF;
          1: return 64'h8000_0000_0000_0000;
          2: return 64'd0;
          default: return '1;
        endcase
      end
      default: return {1'b0, 31'($urandom_range(0, 32'h7FFF_FFFF)), $urandom}
                      >> $urandom_range(0, 40);
    endcase
  endfunction

  function automatic logic [63:0] pick_divisor();
    case ($urandom_range(0, 7))
      0, 1, 2: return 64'($urandom_range(1, 1000));
      3:       return rand_word();
      4:       return 64'd0;
      5:       return -64'($urandom_range(1, 50));
      default: return rand_word() >> $urandom_range(1, 62);
    endcase
  endfunction

  // random items in bursts with gaps; most offset values sit near the origin stamp
  task automatic random_items(int count, bit with_hold, bit with_pause);
    logic [2:0]  op;
    logic [63:0] val;
    logic [63:0] dvs;
    int          burst_left;
    int          gap;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      val = pick_value();
      dvs = pick_divisor();
      if (op == tsr_pkg::OP_DIV && $urandom_range(0, 3) == 0) begin
        // exact half: exercises the tie to even
        dvs = 64'(2 * $urandom_range(1, 500));
        val = dvs * 64'($urandom_range(0, 100000)) + (dvs >> 1);
      end
      if ((op == tsr_pkg::OP_NORM || op == tsr_pkg::OP_SIGNED) && $urandom_range(0, 2) != 0)
        val = sb.regs[tsr_pkg::REG_ORG_STAMP] +
              64'($signed($urandom_range(0, 4000000)) - 2000000);
      if (with_hold && i == count / 3) hold_req = 1'b1;
      if (with_pause && i == count / 2) drain();
      send_item(op, val, dvs);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          din.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    drain();
  endtask

  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TB_MAX  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] TB_MIN  = 64'hFFFF_FFFF_8000_0000;

  initial begin : stimulus
    sb = new();
    sb.reset_regs();
    hold_req = 1'b0;
    settings_run = 1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    din.valid = 1'b0;
    din.operation = '0;
    din.value = '0;
    din.divisor = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 1 us ticks, origin zero, 30 fps
    send_item(tsr_pkg::OP_DIV, 64'd7, 64'd2);         // tie rounds up to even
    send_item(tsr_pkg::OP_DIV, 64'd5, 64'd2);         // tie rounds down to even
    send_item(tsr_pkg::OP_DIV, 64'd1, 64'd3);
    send_item(tsr_pkg::OP_DIV, I64_MAX, 64'd1);
    send_item(tsr_pkg::OP_DIV, I64_MAX, 64'd2);
    send_item(tsr_pkg::OP_DIV, I64_MAX, '1);          // negative divisor
    send_item(tsr_pkg::OP_DIV, 64'd0, 64'd0);         // zero divisor
    send_item(tsr_pkg::OP_DIV, I64_MIN, 64'd1);       // negative dividend
    send_item(tsr_pkg::OP_STAMP, 64'd0, '0);
    send_item(tsr_pkg::OP_STAMP, I64_MAX, '1);
    send_item(tsr_pkg::OP_STAMP, -64'd5, '0);
    send_item(tsr_pkg::OP_NORM, 64'd5, '0);
    send_item(tsr_pkg::OP_NORM, '1, '0);              // before origin
    send_item(tsr_pkg::OP_SIGNED, '1, '0);
    send_item(tsr_pkg::OP_SIGNED, I64_MIN, '0);       // most negative result is legal
    send_item(tsr_pkg::OP_FRAME, 64'd0, '0);
    send_item(tsr_pkg::OP_FRAME, 64'd1, '0);
    send_item(tsr_pkg::OP_FRAME, I64_MAX, '0);        // overflow
    send_item(tsr_pkg::OP_FRAME, '1, '0);             // negative frame index
    send_item(3'd5, 64'd1, 64'd1);                    // unused selectors
    send_item(3'd6, I64_MAX, '1);
    send_item(3'd7, '0, '0);
    drain();

    // nanosecond ticks: offsets below half a microsecond round to zero
    load_setting(64'd1, 64'd1000000000, 64'd1, 64'd1000000000, 64'd1000, 64'd30000, 64'd1001);
    send_item(tsr_pkg::OP_NORM, 64'd999, '0);
    send_item(tsr_pkg::OP_SIGNED, 64'd999, '0);
    send_item(tsr_pkg::OP_SIGNED, 64'd500, '0);
    drain();
    random_items(80, 1'b0, 1'b0);

    // timebase extremes, negative signs, origin at the top of the range
    load_setting(TB_MAX, 64'd1, TB_MIN, '1, I64_MAX, -64'd60, 64'd1);
    random_items(80, 1'b0, 1'b1);

    // zero denominators everywhere, garbage write to the unused index
    load_setting(64'd1, 64'd0, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0);
    write_reg(REG_UNUSED, rand_word());
    random_items(40, 1'b0, 1'b0);

    // negative timebases and origin at the bottom of the range
    load_setting(-64'd1, -64'd1000, 64'd1001, -64'd30000, I64_MIN, -64'd60, -64'd1);
    random_items(80, 1'b1, 1'b0);

    // mpeg ticks with a positive origin, zero rate numerator
    load_setting(64'd1, 64'd90000, 64'd1, 64'd90000, 64'd900000, 64'd0, 64'd1);
    random_items(60, 1'b0, 1'b0);

    // fully random register contents
    for (int k = 0; k < 4; k++) begin
      load_setting(64'($urandom), 64'($urandom), 64'($urandom), 64'($urandom), rand_word(),
                   64'($urandom), 64'($urandom));
      random_items(60, 1'b0, 1'b0);
    end

    // back to common video timebases for the rest
    load_setting(64'd1001, 64'd30000, 64'd1, 64'd1000, 64'd12345, 64'd25, 64'd1);
    random_items(40, 1'b0, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d results over %0d register settings, %0d errors",
             sb.items_in, sb.results_out, settings_run, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sb.pending_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### timestamp_rescale_to_microseconds_top.f
sv/tsr_pkg.sv
sv/tsr_in_if.sv
sv/tsr_out_if.sv
sv/tsr_front.sv
sv/tsr_cell.sv
sv/timestamp_rescale_to_microseconds_top.sv
tb/timestamp_rescale_to_microseconds_top_test.sv
